### sv/crc_framed_serial_deframer_assert.svh
// assertion macros used by the deframer datapath
`ifndef CRC_FRAMED_SERIAL_DEFRAMER_ASSERT_SVH
`define CRC_FRAMED_SERIAL_DEFRAMER_ASSERT_SVH

// property that must hold in the same cycle
`define CFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property whose consequence shows in the cycle after the antecedent
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 56;
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned ADDR_W      = 6;
    localparam int unsigned FILL_W      = 7;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SYNC_FIRST   = 3'd0,
        CFG_SYNC_SECOND  = 3'd1,
        CFG_VERSION      = 3'd2,
        CFG_A_LOW        = 3'd3,
        CFG_A_HIGH       = 3'd4,
        CFG_B_LOW        = 3'd5,
        CFG_B_HIGH       = 3'd6,
        CFG_GAP_TIMEOUT  = 3'd7
    } cfg_idx_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_GAP,
        OP_APPEND,
        OP_HDR_START,
        OP_RD,
        OP_HDR_USE,
        OP_PL_USE,
        OP_CK_USE,
        OP_CRC_FAIL,
        OP_EM_START,
        OP_EM_USE,
        OP_MARK,
        OP_CONSUME,
        OP_RS_START,
        OP_RS_USE,
        OP_RS_APPLY,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cfd_cmd_t;

    typedef struct packed {
        logic gap_expired;
        logic fill_lt_hdr;
        logic len_bad;
        logic fill_lt_total;
        logic plen_zero;
        logic hdr_last;
        logic pl_last;
        logic ck_last;
        logic crc_bad;
        logic wanted;
        logic can_emit;
        logic flush_ok;
        logic rs_small;
        logic rs_stop;
    } cfd_status_t;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/crc_framed_serial_deframer.sv
`timescale 1ns / 1ps
// processing: an accepted byte is latched, checked against the gap timeout, appended and then parsed;
// a buffered header is read and checked, then payload and check bytes are read and the crc compared;
// a wanted frame emits each payload byte (an empty one a marker), waiting whenever m_ready holds the output
// a resync scans the buffered bytes for the sync pair; input is taken only in idle, one item at a time
// throughput is bounded by the single-port 64-byte frame store, which serves one access at a time
// reset: synchronous active low; clears counters, fill level and config to defaults

module crc_framed_serial_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_arrival_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_kind,
    output logic [7:0]  m_payload_value,
    output logic [5:0]  m_payload_offset,
    output logic [5:0]  m_payload_size,
    output logic        m_no_payload,
    output logic        m_frame_end,
    output logic        m_run_end,
    output logic [31:0] m_crc_fail_total,
    output logic [31:0] m_resync_total
);

    cfd_pkg::cfd_cmd_t    cmd;
    cfd_pkg::cfd_status_t status;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    cfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfd_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_rx_byte        (s_rx_byte),
        .s_arrival_ms     (s_arrival_ms),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_kind     (m_frame_kind),
        .m_payload_value  (m_payload_value),
        .m_payload_offset (m_payload_offset),
        .m_payload_size   (m_payload_size),
        .m_no_payload     (m_no_payload),
        .m_frame_end      (m_frame_end),
        .m_run_end        (m_run_end),
        .m_crc_fail_total (m_crc_fail_total),
        .m_resync_total   (m_resync_total)
    );

endmodule

### sv/cfd_ram.sv
`timescale 1ns / 1ps

module cfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

### sv/cfd_datapath.sv
`timescale 1ns / 1ps
`include "crc_framed_serial_deframer_assert.svh"

module cfd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfd_pkg::cfd_cmd_t    cmd,
    output cfd_pkg::cfd_status_t status,
    input  logic [7:0]           s_rx_byte,
    input  logic [31:0]          s_arrival_ms,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_frame_kind,
    output logic [7:0]           m_payload_value,
    output logic [5:0]           m_payload_offset,
    output logic [5:0]           m_payload_size,
    output logic                 m_no_payload,
    output logic                 m_frame_end,
    output logic                 m_run_end,
    output logic [31:0]          m_crc_fail_total,
    output logic [31:0]          m_resync_total
);

    // configuration
    logic [7:0]  sync_first_reg, sync_second_reg, version_cfg_reg;
    logic [7:0]  a_low_reg, a_high_reg, b_low_reg, b_high_reg;
    logic [31:0] gap_timeout_reg;

    // input item and buffer state
    logic [7:0]  rx_byte_reg;
    logic [31:0] arrival_reg, last_arrival_reg;
    logic [cfd_pkg::ADDR_W-1:0] base_reg;
    logic [cfd_pkg::FILL_W-1:0] fill_reg, idx_reg;
    logic [31:0] crc_fail_reg, resync_reg;

    // frame parse
    logic [15:0] crc_reg, got_reg;
    logic [7:0]  ver_reg, type_reg, len_lo_reg, len_hi_reg;

    // resync scan
    logic [7:0]  rs_prev_reg;
    logic        rs_found_reg, rs_last_sf_reg;
    logic [cfd_pkg::FILL_W-1:0] rs_pos_reg;

    // staged result, held until the next one or the end of the item is known
    logic        pend_valid_reg;
    logic [7:0]  pend_kind_reg, pend_value_reg;
    logic [5:0]  pend_offset_reg, pend_size_reg;
    logic        pend_empty_reg, pend_end_reg;
    logic [31:0] pend_crc_reg, pend_rs_reg;

    // output register
    logic        m_valid_reg;
    logic [7:0]  m_kind_reg, m_value_reg;
    logic [5:0]  m_offset_reg, m_size_reg;
    logic        m_empty_reg, m_end_reg, m_run_end_reg;
    logic [31:0] m_crc_reg, m_rs_reg;

    logic [7:0]  rdata;
    logic        ram_we, ram_re;
    logic [cfd_pkg::ADDR_W-1:0] ram_addr;
    logic        append_write;
    logic [cfd_pkg::FILL_W-1:0] fill_append;
    logic [15:0] plen16;
    logic [5:0]  plen6;
    logic [cfd_pkg::FILL_W-1:0] total7, pl_end7, ck_lo7, ck_end7;
    logic [31:0] gap_elapsed;
    logic        out_free, push, rs_found_now;
    logic        type_in_a, type_in_b;
    cfd_pkg::dp_op_t op;

    assign op = cmd.op;

    // length and frame positions
    assign plen16  = {len_hi_reg, len_lo_reg};
    assign plen6   = len_lo_reg[5:0];
    assign total7  = cfd_pkg::FILL_W'(plen6) + 7'd8;
    assign pl_end7 = cfd_pkg::FILL_W'(plen6) + 7'd5;
    assign ck_lo7  = cfd_pkg::FILL_W'(plen6) + 7'd6;
    assign ck_end7 = cfd_pkg::FILL_W'(plen6) + 7'd7;

    // append decision for the new byte
    always_comb begin
        append_write = 1'b0;
        fill_append  = fill_reg;
        if (fill_reg == 7'd0) begin
            if (rx_byte_reg == sync_first_reg) begin
                append_write = 1'b1;
                fill_append  = 7'd1;
            end
        end else if (fill_reg == 7'd1) begin
            if (rx_byte_reg == sync_second_reg) begin
                append_write = 1'b1;
                fill_append  = 7'd2;
            end else if (rx_byte_reg != sync_first_reg) begin
                fill_append = 7'd0;
            end
        end else if (fill_reg < 7'(cfd_pkg::STORE_DEPTH)) begin
            append_write = 1'b1;
            fill_append  = fill_reg + 7'd1;
        end
    end

    // store access: ring buffer addressed from base
    assign ram_we   = (op == cfd_pkg::OP_APPEND) && append_write;
    assign ram_re   = (op == cfd_pkg::OP_RD);
    assign ram_addr = ram_we ? base_reg + fill_reg[cfd_pkg::ADDR_W-1:0]
                             : base_reg + idx_reg[cfd_pkg::ADDR_W-1:0];

    cfd_ram #(
        .WIDTH (8),
        .DEPTH (cfd_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (rx_byte_reg),
        .rdata (rdata)
    );

    // status toward the controller
    assign gap_elapsed  = arrival_reg - last_arrival_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign type_in_a    = (type_reg >= a_low_reg) && (type_reg <= a_high_reg);
    assign type_in_b    = (type_reg >= b_low_reg) && (type_reg <= b_high_reg);
    assign rs_found_now = (idx_reg >= 7'd2) && (rs_prev_reg == sync_first_reg)
                          && (rdata == sync_second_reg);

    always_comb begin
        status.gap_expired   = (fill_reg != 7'd0) && (gap_elapsed > gap_timeout_reg);
        status.fill_lt_hdr   = fill_reg < 7'd6;
        status.len_bad       = plen16 > 16'(cfd_pkg::MAX_PAYLOAD);
        status.fill_lt_total = fill_reg < total7;
        status.plen_zero     = plen6 == 6'd0;
        status.hdr_last      = idx_reg == 7'd5;
        status.pl_last       = idx_reg == pl_end7;
        status.ck_last       = idx_reg == ck_end7;
        status.crc_bad       = got_reg != crc_reg;
        status.wanted        = (ver_reg == version_cfg_reg) && (type_in_a || type_in_b);
        status.can_emit      = !pend_valid_reg || out_free;
        status.flush_ok      = !pend_valid_reg || out_free;
        status.rs_small      = fill_reg < 7'd2;
        status.rs_stop       = rs_found_now || (idx_reg == fill_reg - 7'd1);
    end

    assign push = pend_valid_reg && ((op == cfd_pkg::OP_EM_USE) || (op == cfd_pkg::OP_MARK)
                                     || (op == cfd_pkg::OP_FLUSH));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= 8'd0;
            sync_second_reg <= 8'd0;
            version_cfg_reg <= 8'd1;
            a_low_reg       <= 8'd0;
            a_high_reg      <= 8'd0;
            b_low_reg       <= 8'd0;
            b_high_reg      <= 8'd0;
            gap_timeout_reg <= 32'd100;
        end else if (cfg_valid) begin
            unique case (cfd_pkg::cfg_idx_t'(cfg_index))
                cfd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                cfd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                cfd_pkg::CFG_VERSION:     version_cfg_reg <= cfg_data[7:0];
                cfd_pkg::CFG_A_LOW:       a_low_reg       <= cfg_data[7:0];
                cfd_pkg::CFG_A_HIGH:      a_high_reg      <= cfg_data[7:0];
                cfd_pkg::CFG_B_LOW:       b_low_reg       <= cfg_data[7:0];
                cfd_pkg::CFG_B_HIGH:      b_high_reg      <= cfg_data[7:0];
                cfd_pkg::CFG_GAP_TIMEOUT: gap_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // buffer control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_arrival_reg <= 32'd0;
            base_reg         <= '0;
            fill_reg         <= '0;
            crc_fail_reg     <= 32'd0;
            resync_reg       <= 32'd0;
            pend_valid_reg   <= 1'b0;
        end else begin
            case (op) inside
                cfd_pkg::OP_GAP:      last_arrival_reg <= arrival_reg;
                cfd_pkg::OP_APPEND:   fill_reg <= fill_append;
                cfd_pkg::OP_CRC_FAIL: crc_fail_reg <= crc_fail_reg + 32'd1;
                cfd_pkg::OP_CONSUME: begin
                    base_reg <= base_reg + total7[cfd_pkg::ADDR_W-1:0];
                    fill_reg <= fill_reg - total7;
                end
                cfd_pkg::OP_RS_APPLY: begin
                    resync_reg <= resync_reg + 32'd1;
                    if (rs_found_reg) begin
                        base_reg <= base_reg + rs_pos_reg[cfd_pkg::ADDR_W-1:0];
                        fill_reg <= fill_reg - rs_pos_reg;
                    end else if (rs_last_sf_reg) begin
                        base_reg <= base_reg + (fill_reg[cfd_pkg::ADDR_W-1:0] - 6'd1);
                        fill_reg <= 7'd1;
                    end else begin
                        fill_reg <= 7'd0;
                    end
                end
                cfd_pkg::OP_EM_USE, cfd_pkg::OP_MARK: pend_valid_reg <= 1'b1;
                cfd_pkg::OP_FLUSH:    pend_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // parse and scan payload registers
    always_ff @(posedge aclk) begin
        case (op)
            cfd_pkg::OP_LATCH: begin
                rx_byte_reg <= s_rx_byte;
                arrival_reg <= s_arrival_ms;
            end
            cfd_pkg::OP_HDR_START: begin
                idx_reg <= 7'd2;
                crc_reg <= cfd_pkg::CRC_INIT;
            end
            cfd_pkg::OP_HDR_USE: begin
                case (idx_reg[1:0])
                    2'd2:    ver_reg    <= rdata;
                    2'd3:    type_reg   <= rdata;
                    2'd0:    len_lo_reg <= rdata;
                    default: len_hi_reg <= rdata;
                endcase
                crc_reg <= cfd_pkg::crc_byte(crc_reg, rdata);
                idx_reg <= idx_reg + 7'd1;
            end
            cfd_pkg::OP_PL_USE: begin
                crc_reg <= cfd_pkg::crc_byte(crc_reg, rdata);
                idx_reg <= idx_reg + 7'd1;
            end
            cfd_pkg::OP_CK_USE: begin
                if (idx_reg == ck_lo7) begin
                    got_reg[7:0] <= rdata;
                end else begin
                    got_reg[15:8] <= rdata;
                end
                idx_reg <= idx_reg + 7'd1;
            end
            cfd_pkg::OP_EM_START: idx_reg <= 7'd6;
            cfd_pkg::OP_EM_USE: begin
                pend_kind_reg   <= type_reg;
                pend_value_reg  <= rdata;
                pend_offset_reg <= idx_reg[5:0] - 6'd6;
                pend_size_reg   <= plen6;
                pend_empty_reg  <= 1'b0;
                pend_end_reg    <= idx_reg == pl_end7;
                pend_crc_reg    <= crc_fail_reg;
                pend_rs_reg     <= resync_reg;
                idx_reg         <= idx_reg + 7'd1;
            end
            cfd_pkg::OP_MARK: begin
                pend_kind_reg   <= type_reg;
                pend_value_reg  <= 8'd0;
                pend_offset_reg <= 6'd0;
                pend_size_reg   <= 6'd0;
                pend_empty_reg  <= 1'b1;
                pend_end_reg    <= 1'b1;
                pend_crc_reg    <= crc_fail_reg;
                pend_rs_reg     <= resync_reg;
            end
            cfd_pkg::OP_RS_START: begin
                idx_reg        <= 7'd1;
                rs_found_reg   <= 1'b0;
                rs_last_sf_reg <= 1'b0;
            end
            cfd_pkg::OP_RS_USE: begin
                rs_prev_reg    <= rdata;
                rs_last_sf_reg <= rdata == sync_first_reg;
                if (rs_found_now) begin
                    rs_found_reg <= 1'b1;
                    rs_pos_reg   <= idx_reg - 7'd1;
                end
                idx_reg <= idx_reg + 7'd1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_kind_reg    <= pend_kind_reg;
            m_value_reg   <= pend_value_reg;
            m_offset_reg  <= pend_offset_reg;
            m_size_reg    <= pend_size_reg;
            m_empty_reg   <= pend_empty_reg;
            m_end_reg     <= pend_end_reg;
            m_run_end_reg <= op == cfd_pkg::OP_FLUSH;
            m_crc_reg     <= pend_crc_reg;
            m_rs_reg      <= pend_rs_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_kind     = m_kind_reg;
    assign m_payload_value  = m_value_reg;
    assign m_payload_offset = m_offset_reg;
    assign m_payload_size   = m_size_reg;
    assign m_no_payload     = m_empty_reg;
    assign m_frame_end      = m_end_reg;
    assign m_run_end        = m_run_end_reg;
    assign m_crc_fail_total = m_crc_reg;
    assign m_resync_total   = m_rs_reg;

    // checks
    `CFD_ASSERT(a_fill_bound, fill_reg <= 7'(cfd_pkg::STORE_DEPTH), "fill level above store depth")
    `CFD_ASSERT(a_push_free, !push || out_free, "result pushed over an untaken result")
    `CFD_ASSERT_NEXT(a_resync_count, op == cfd_pkg::OP_RS_APPLY, resync_reg == $past(resync_reg) + 32'd1, "resync count did not step")

endmodule

### sv/cfd_ctrl.sv
`timescale 1ns / 1ps

module cfd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cfd_pkg::cfd_status_t status,
    output cfd_pkg::cfd_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_GAP, S_APPEND, S_PARSE,
        S_HDR_RD, S_HDR_USE, S_LEN,
        S_PL_RD, S_PL_USE, S_CK_RD, S_CK_USE, S_CMP,
        S_EM_RD, S_EM_USE, S_MARK, S_CONSUME, S_FLUSH,
        S_RS_START, S_RS_RD, S_RS_USE, S_RS_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   ret_parse_reg, ret_parse_next;

    // next state and datapath command
    always_comb begin
        state_next     = state_reg;
        ret_parse_next = ret_parse_reg;
        cmd.op         = cfd_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = cfd_pkg::OP_LATCH;
                    state_next = S_GAP;
                end
            end
            S_GAP: begin
                cmd.op = cfd_pkg::OP_GAP;
                if (status.gap_expired) begin
                    ret_parse_next = 1'b0;
                    state_next     = S_RS_START;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND: begin
                cmd.op     = cfd_pkg::OP_APPEND;
                state_next = S_PARSE;
            end
            S_PARSE: begin
                if (status.fill_lt_hdr) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.op     = cfd_pkg::OP_HDR_START;
                    state_next = S_HDR_RD;
                end
            end
            S_HDR_RD: begin
                cmd.op     = cfd_pkg::OP_RD;
                state_next = S_HDR_USE;
            end
            S_HDR_USE: begin
                cmd.op     = cfd_pkg::OP_HDR_USE;
                state_next = status.hdr_last ? S_LEN : S_HDR_RD;
            end
            S_LEN: begin
                if (status.len_bad) begin
                    ret_parse_next = 1'b1;
                    state_next     = S_RS_START;
                end else if (status.fill_lt_total) begin
                    state_next = S_FLUSH;
                end else begin
                    state_next = status.plen_zero ? S_CK_RD : S_PL_RD;
                end
            end
            S_PL_RD: begin
                cmd.op     = cfd_pkg::OP_RD;
                state_next = S_PL_USE;
            end
            S_PL_USE: begin
                cmd.op     = cfd_pkg::OP_PL_USE;
                state_next = status.pl_last ? S_CK_RD : S_PL_RD;
            end
            S_CK_RD: begin
                cmd.op     = cfd_pkg::OP_RD;
                state_next = S_CK_USE;
            end
            S_CK_USE: begin
                cmd.op     = cfd_pkg::OP_CK_USE;
                state_next = status.ck_last ? S_CMP : S_CK_RD;
            end
            S_CMP: begin
                if (status.crc_bad) begin
                    cmd.op         = cfd_pkg::OP_CRC_FAIL;
                    ret_parse_next = 1'b1;
                    state_next     = S_RS_START;
                end else if (!status.wanted) begin
                    state_next = S_CONSUME;
                end else if (status.plen_zero) begin
                    state_next = S_MARK;
                end else begin
                    cmd.op     = cfd_pkg::OP_EM_START;
                    state_next = S_EM_RD;
                end
            end
            S_EM_RD: begin
                cmd.op     = cfd_pkg::OP_RD;
                state_next = S_EM_USE;
            end
            S_EM_USE: begin
                if (status.can_emit) begin
                    cmd.op     = cfd_pkg::OP_EM_USE;
                    state_next = status.pl_last ? S_CONSUME : S_EM_RD;
                end
            end
            S_MARK: begin
                if (status.can_emit) begin
                    cmd.op     = cfd_pkg::OP_MARK;
                    state_next = S_CONSUME;
                end
            end
            S_CONSUME: begin
                cmd.op     = cfd_pkg::OP_CONSUME;
                state_next = S_PARSE;
            end
            S_FLUSH: begin
                if (status.flush_ok) begin
                    cmd.op     = cfd_pkg::OP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            S_RS_START: begin
                cmd.op     = cfd_pkg::OP_RS_START;
                state_next = status.rs_small ? S_RS_APPLY : S_RS_RD;
            end
            S_RS_RD: begin
                cmd.op     = cfd_pkg::OP_RD;
                state_next = S_RS_USE;
            end
            S_RS_USE: begin
                cmd.op     = cfd_pkg::OP_RS_USE;
                state_next = status.rs_stop ? S_RS_APPLY : S_RS_RD;
            end
            S_RS_APPLY: begin
                cmd.op     = cfd_pkg::OP_RS_APPLY;
                state_next = ret_parse_reg ? S_PARSE : S_APPEND;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_parse_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_parse_reg <= ret_parse_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

### verif/deframer_checker.sv
`timescale 1ns / 1ps

module deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_arrival_ms,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_frame_kind,
    input  logic [7:0]  m_payload_value,
    input  logic [5:0]  m_payload_offset,
    input  logic [5:0]  m_payload_size,
    input  logic        m_no_payload,
    input  logic        m_frame_end,
    input  logic        m_run_end,
    input  logic [31:0] m_crc_fail_total,
    input  logic [31:0] m_resync_total,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  value;
        logic [5:0]  offset;
        logic [5:0]  size;
        logic        empty;
        logic        fend;
        logic        rend;
        logic [31:0] crc_fails;
        logic [31:0] resyncs;
    } payload_item_t;

    payload_item_t pending_items[$];

    // shadow configuration
    logic [7:0]  sh_sync1, sh_sync2, sh_version, sh_alo, sh_ahi, sh_blo, sh_bhi;
    logic [31:0] sh_gap;

    // shadow buffer state
    logic [7:0]  buf_q[64];
    int unsigned buf_fill;
    logic [31:0] prev_ms;
    logic [31:0] crc_fails, resyncs;

    assign pending_count = pending_items.size();

    function automatic logic [15:0] frame_crc(int unsigned count);
        logic [15:0] c;
        c = 16'hffff;
        for (int k = 0; k < count; k++) begin
            c ^= {buf_q[2 + k], 8'h00};
            for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic realign();
        int unsigned keep;
        keep = 0;
        for (int unsigned i = 1; i + 1 < buf_fill; i++) begin
            if (buf_q[i] == sh_sync1 && buf_q[i + 1] == sh_sync2) begin
                keep = buf_fill - i;
                for (int unsigned j = 0; j < keep; j++) buf_q[j] = buf_q[i + j];
                break;
            end
        end
        if (keep == 0 && buf_fill > 1 && buf_q[buf_fill - 1] == sh_sync1) begin
            buf_q[0] = sh_sync1;
            keep = 1;
        end
        buf_fill = keep;
        resyncs++;
    endtask

    // advance the shadow deframer by one byte and queue the payload items it releases
    task automatic deframe_byte(logic [7:0] b, logic [31:0] now);
        int unsigned plen, total, rest;
        int n;
        logic [7:0] kind;
        payload_item_t it;
        n = 0;
        if (buf_fill != 0 && (now - prev_ms) > sh_gap) realign();
        prev_ms = now;
        if (buf_fill == 0) begin
            if (b == sh_sync1) buf_q[buf_fill++] = b;
        end else if (buf_fill == 1) begin
            if (b == sh_sync2) buf_q[buf_fill++] = b;
            else if (b != sh_sync1) buf_fill = 0;
        end else if (buf_fill < 64) begin
            buf_q[buf_fill++] = b;
        end
        forever begin
            if (buf_fill < 6) break;
            plen = {buf_q[5], buf_q[4]};
            if (plen > cfd_pkg::MAX_PAYLOAD) begin
                realign();
                continue;
            end
            total = plen + 8;
            if (buf_fill < total) break;
            if ({buf_q[plen + 7], buf_q[plen + 6]} != frame_crc(plen + 4)) begin
                crc_fails++;
                realign();
                continue;
            end
            kind = buf_q[3];
            if (buf_q[2] == sh_version && ((kind >= sh_alo && kind <= sh_ahi) ||
                                           (kind >= sh_blo && kind <= sh_bhi))) begin
                for (int unsigned k = 0; k < (plen == 0 ? 1 : plen); k++) begin
                    if (n < 64) begin
                        it.kind = kind;
                        it.value = (plen == 0) ? 8'h00 : buf_q[6 + k];
                        it.offset = k;
                        it.size = plen;
                        it.empty = (plen == 0);
                        it.fend = (plen == 0) || (k + 1 == plen);
                        it.rend = 1'b0;
                        it.crc_fails = crc_fails;
                        it.resyncs = resyncs;
                        pending_items.push_back(it);
                        n++;
                    end
                end
            end
            rest = buf_fill - total;
            for (int unsigned j = 0; j < rest; j++) buf_q[j] = buf_q[total + j];
            buf_fill = rest;
        end
        if (n > 0) pending_items[pending_items.size() - 1].rend = 1'b1;
    endtask

    // compare one delivered item against the oldest prediction
    task automatic compare_item();
        payload_item_t exp_it, got;
        got = '{m_frame_kind, m_payload_value, m_payload_offset, m_payload_size,
                m_no_payload, m_frame_end, m_run_end, m_crc_fail_total, m_resync_total};
        if (pending_items.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            fail_count++;
        end else begin
            exp_it = pending_items.pop_front();
            if (exp_it.kind != got.kind)
                $display("%0t: frame_kind exp %h got %h", $time, exp_it.kind, got.kind);
            if (exp_it.value != got.value)
                $display("%0t: payload_value exp %h got %h", $time, exp_it.value, got.value);
            if (exp_it.offset != got.offset)
                $display("%0t: payload_offset exp %0d got %0d", $time, exp_it.offset, got.offset);
            if (exp_it.size != got.size)
                $display("%0t: payload_size exp %0d got %0d", $time, exp_it.size, got.size);
            if (exp_it.empty != got.empty)
                $display("%0t: no_payload exp %b got %b", $time, exp_it.empty, got.empty);
            if (exp_it.fend != got.fend)
                $display("%0t: frame_end exp %b got %b", $time, exp_it.fend, got.fend);
            if (exp_it.rend != got.rend)
                $display("%0t: run_end exp %b got %b", $time, exp_it.rend, got.rend);
            if (exp_it.crc_fails != got.crc_fails)
                $display("%0t: crc_fail_total exp %0d got %0d", $time, exp_it.crc_fails,
                         got.crc_fails);
            if (exp_it.resyncs != got.resyncs)
                $display("%0t: resync_total exp %0d got %0d", $time, exp_it.resyncs,
                         got.resyncs);
            if (exp_it != got) fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sh_sync1 = 0; sh_sync2 = 0; sh_version = 1;
            sh_alo = 0; sh_ahi = 0; sh_blo = 0; sh_bhi = 0;
            sh_gap = 100;
            buf_fill = 0; prev_ms = 0; crc_fails = 0; resyncs = 0;
            pending_items.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) compare_item();
            if (cfg_valid && cfg_ready) begin
                case (cfd_pkg::cfg_idx_t'(cfg_index))
                    cfd_pkg::CFG_SYNC_FIRST:  sh_sync1 = cfg_data[7:0];
                    cfd_pkg::CFG_SYNC_SECOND: sh_sync2 = cfg_data[7:0];
                    cfd_pkg::CFG_VERSION:     sh_version = cfg_data[7:0];
                    cfd_pkg::CFG_A_LOW:       sh_alo = cfg_data[7:0];
                    cfd_pkg::CFG_A_HIGH:      sh_ahi = cfg_data[7:0];
                    cfd_pkg::CFG_B_LOW:       sh_blo = cfg_data[7:0];
                    cfd_pkg::CFG_B_HIGH:      sh_bhi = cfg_data[7:0];
                    cfd_pkg::CFG_GAP_TIMEOUT: sh_gap = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) deframe_byte(s_rx_byte, s_arrival_ms);
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic [31:0] s_arrival_ms = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_frame_kind, m_payload_value;
    logic [5:0]  m_payload_offset, m_payload_size;
    logic        m_no_payload, m_frame_end, m_run_end;
    logic [31:0] m_crc_fail_total, m_resync_total;
    int          fail_count, pending_count;

    // stimulus state
    logic [7:0]  cur_sync1, cur_sync2, cur_version;
    logic [31:0] clock_ms;
    logic [7:0]  tx_frame[72];
    int          tx_len;
    int          idle_cycles;
    bit          rx_free_run, rx_hold, tx_free_run;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    crc_framed_serial_deframer u_top (.*);

    deframer_checker u_chk (.*);

    // receiver side back-pressure
    always @(posedge aclk) begin
        if (rx_hold) m_ready <= 1'b0;
        else m_ready <= rx_free_run ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // watchdog on accepted handshakes
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high after the write; set_config drops it after the last one
    task automatic write_reg(cfd_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // valid drops only while idling or draining
    task automatic send_byte(logic [7:0] b, logic [31:0] ms);
        while (!tx_free_run && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        s_arrival_ms <= ms;
        do @(posedge aclk); while (!s_ready);
    endtask

    // send bytes with a small advancing timestamp
    task automatic send_seq(int n);
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(3);
            send_byte(tx_frame[i], clock_ms);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    function automatic logic [15:0] crc16(int count);
        logic [15:0] c;
        c = 16'hffff;
        for (int k = 0; k < count; k++) begin
            c ^= {tx_frame[2 + k], 8'h00};
            for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // build a frame in tx_frame; bad_crc corrupts the check
    task automatic build_frame(logic [7:0] ver, logic [7:0] kind, int plen, bit bad_crc);
        logic [15:0] c;
        tx_frame[0] = cur_sync1;
        tx_frame[1] = cur_sync2;
        tx_frame[2] = ver;
        tx_frame[3] = kind;
        tx_frame[4] = plen[7:0];
        tx_frame[5] = 8'h00;
        for (int k = 0; k < plen; k++) tx_frame[6 + k] = $urandom_range(255);
        c = crc16(plen + 4);
        if (bad_crc) c ^= 16'h0001 << $urandom_range(15);
        tx_frame[6 + plen] = c[7:0];
        tx_frame[7 + plen] = c[15:8];
        tx_len = plen + 8;
    endtask

    task automatic set_config(logic [7:0] s1, logic [7:0] s2, logic [7:0] ver,
                              logic [7:0] alo, logic [7:0] ahi, logic [7:0] blo,
                              logic [7:0] bhi, logic [31:0] gap);
        write_reg(cfd_pkg::CFG_SYNC_FIRST, s1);
        write_reg(cfd_pkg::CFG_SYNC_SECOND, s2);
        write_reg(cfd_pkg::CFG_VERSION, ver);
        write_reg(cfd_pkg::CFG_A_LOW, alo);
        write_reg(cfd_pkg::CFG_A_HIGH, ahi);
        write_reg(cfd_pkg::CFG_B_LOW, blo);
        write_reg(cfd_pkg::CFG_B_HIGH, bhi);
        write_reg(cfd_pkg::CFG_GAP_TIMEOUT, gap);
        cfg_valid <= 1'b0;
        cur_sync1 = s1;
        cur_sync2 = s2;
        cur_version = ver;
    endtask

    // one random piece of traffic: mostly good frames, some noise and damage
    task automatic random_traffic();
        int pick, plen;
        pick = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(cfd_pkg::MAX_PAYLOAD)
                                        : $urandom_range(6);
        build_frame(($urandom_range(7) == 0) ? 8'($urandom) : cur_version,
                    8'($urandom), plen, pick < 10);
        if (pick < 70) begin
            send_seq(tx_len);
        end else if (pick < 78) begin
            // truncated frame followed by a late byte 500 ms later
            send_seq($urandom_range(tx_len - 1, 2));
            clock_ms += 32'd500;
            send_byte(8'($urandom), clock_ms);
        end else if (pick < 85) begin
            // oversize length field
            tx_frame[4] = 8'($urandom_range(255, 57));
            tx_frame[5] = 8'($urandom);
            send_seq(6);
        end else begin
            for (int i = 0; i < tx_len; i++) tx_frame[i] = 8'($urandom);
            send_seq($urandom_range(6, 1));
        end
    endtask

    initial begin
        rx_free_run = 1'b0;
        rx_hold = 1'b0;
        tx_free_run = 1'b0;
        clock_ms = 32'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wide ranges, distinct sync bytes
        set_config(8'hA5, 8'h5A, 8'h01, 8'h00, 8'h7F, 8'h80, 8'hFF, 32'd100);
        build_frame(8'h01, 8'h00, 0, 0);  send_seq(tx_len);     // empty marker
        build_frame(8'h01, 8'hFF, 3, 0);  send_seq(tx_len);
        build_frame(8'h01, 8'h10, 56, 0); send_seq(tx_len);    // largest payload
        build_frame(8'h01, 8'h11, 2, 1);  send_seq(tx_len);    // bad crc
        build_frame(8'h02, 8'h11, 1, 0);  send_seq(tx_len);    // wrong version
        // repeated first magic byte while hunting, then a stray byte
        tx_frame[0] = 8'hA5; tx_frame[1] = 8'hA5; tx_frame[2] = 8'h00;
        tx_frame[3] = 8'hA5; tx_frame[4] = 8'hFF;
        send_seq(5);
        // oversize length
        build_frame(8'h01, 8'h01, 0, 0); tx_frame[4] = 8'hFF; tx_frame[5] = 8'hFF;
        send_seq(6);
        // timestamp extremes and a gap
        send_byte(8'hA5, 32'hFFFF_FFFF);
        send_byte(8'h5A, 32'h0000_0000);
        send_byte(8'h01, 32'd200);
        drain();

        // equal magic bytes, empty range a, narrow b, zero timeout
        set_config(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h20, 8'h20, 32'd0);
        for (int i = 0; i < 10; i++) random_traffic();
        drain();

        // maximum timeout, all-ones magic
        set_config(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
        tx_free_run = 1'b1;
        for (int i = 0; i < 8; i++) random_traffic();
        tx_free_run = 1'b0;
        drain();

        // random settings with receiver hold-off to fill the block
        set_config(8'($urandom), 8'($urandom), 8'($urandom_range(3)), 8'h00, 8'h9F,
                   8'hB0, 8'hFF, 32'd50);
        fork
            begin
                rx_hold = 1'b1;
                repeat (1500) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++) random_traffic();
        join
        rx_free_run = 1'b1;
        for (int i = 0; i < 4; i++) random_traffic();
        rx_free_run = 1'b0;
        drain();

        set_config(8'h7E, 8'h81, 8'h01, 8'h00, 8'hFF, 8'h01, 8'h00, 32'd10);
        for (int i = 0; i < 4; i++) random_traffic();
        drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/cfd_pkg.sv
sv/cfd_ram.sv
sv/cfd_datapath.sv
sv/cfd_ctrl.sv
sv/crc_framed_serial_deframer.sv
verif/deframer_checker.sv
verif/tb.sv
